// ===== rtl/core/triangle_conduction_element_matrix_core_assert.svh =====
// Assertion macros for the triangle conduction element matrix core
`ifndef TRIANGLE_CONDUCTION_ELEMENT_MATRIX_CORE_ASSERT_SVH
`define TRIANGLE_CONDUCTION_ELEMENT_MATRIX_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TCEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCEM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCEM_ASSERT(lbl, prop, msg)
`define TCEM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/tcem_pkg.sv =====
// Shared widths, types and entry tables for the element matrix core
`timescale 1ns / 1ps
package tcem_pkg;
  localparam int CRD_W    = 24;
  localparam int NCRD     = 6;
  localparam int DIF_W    = CRD_W + 1;
  localparam int PRD_W    = 2 * DIF_W;
  localparam int SUM_W    = PRD_W + 1;
  localparam int MAG_W    = PRD_W;
  localparam int HALF_W   = MAG_W / 2;
  localparam int LAM_W    = 32;
  localparam int PP_W     = LAM_W + HALF_W;
  localparam int PRO_W    = LAM_W + MAG_W;
  localparam int DEN_W    = SUM_W;
  localparam int Q_W      = 32;
  localparam int AREA_W   = 48;
  localparam int NENT     = 6;
  localparam int GEO_LAT  = 4;
  localparam int LANE_LAT = 3 + Q_W + 1;
  localparam int PIPE_LAT = GEO_LAT + LANE_LAT;
  localparam int IN_W     = NCRD * CRD_W;
  localparam int OUT_W    = NENT * Q_W + AREA_W;

  localparam logic [LAM_W-1:0] LAM_RESET = 32'h0001_0000;
  localparam logic [Q_W-1:0]   ENT_MAX   = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0]   ENT_MIN   = 32'h8000_0000;

  // upper-triangle entry order: aa, ab, ac, bb, bc, cc
  localparam logic [1:0] ROW_IDX [NENT] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] COL_IDX [NENT] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef struct packed {
    logic [NENT-1:0][MAG_W-1:0] nmag;
    logic [NENT-1:0]            neg;
    logic [DEN_W-1:0]           d;
    logic [AREA_W-1:0]          area;
    logic                       degen;
  } geo_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   pl;
    logic [Q_W-1:0]   q;
    logic [DEN_W-1:0] d;
    logic             neg;
    logic             ovf;
  } step_t;

  function automatic logic signed [DIF_W-1:0] sub_crd(crd_t a, crd_t b);
    return DIF_W'(a) - DIF_W'(b);
  endfunction
endpackage

// ===== rtl/core/tcem_geom.sv =====
// Geometry front end: differences, products, sums, magnitudes and area
`timescale 1ns / 1ps
module tcem_geom (
  input  logic                clk,
  input  logic                en,
  input  tcem_pkg::crd_t      crd [tcem_pkg::NCRD],
  output tcem_pkg::geo_t      geo
);
  logic signed [tcem_pkg::DIF_W-1:0] b_r  [3];
  logic signed [tcem_pkg::DIF_W-1:0] c_r  [3];
  logic signed [tcem_pkg::DIF_W-1:0] b_nxt [3];
  logic signed [tcem_pkg::DIF_W-1:0] c_nxt [3];
  logic signed [tcem_pkg::PRD_W-1:0] pb_r [tcem_pkg::NENT];
  logic signed [tcem_pkg::PRD_W-1:0] pc_r [tcem_pkg::NENT];
  logic signed [tcem_pkg::PRD_W-1:0] dp1_r, dp2_r;
  logic signed [tcem_pkg::SUM_W-1:0] n_r [tcem_pkg::NENT];
  logic signed [tcem_pkg::SUM_W-1:0] dd_r;
  tcem_pkg::geo_t geo_r, geo_nxt;

  always_comb begin
    b_nxt[0] = tcem_pkg::sub_crd(crd[3], crd[5]);
    b_nxt[1] = tcem_pkg::sub_crd(crd[5], crd[1]);
    b_nxt[2] = tcem_pkg::sub_crd(crd[1], crd[3]);
    c_nxt[0] = tcem_pkg::sub_crd(crd[4], crd[2]);
    c_nxt[1] = tcem_pkg::sub_crd(crd[0], crd[4]);
    c_nxt[2] = tcem_pkg::sub_crd(crd[2], crd[0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b_r[i] <= b_nxt[i];
        c_r[i] <= c_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < tcem_pkg::NENT; k++) begin
        pb_r[k] <= b_r[tcem_pkg::ROW_IDX[k]] * b_r[tcem_pkg::COL_IDX[k]];
        pc_r[k] <= c_r[tcem_pkg::ROW_IDX[k]] * c_r[tcem_pkg::COL_IDX[k]];
      end
      dp1_r <= c_r[2] * b_r[1];
      dp2_r <= c_r[1] * b_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < tcem_pkg::NENT; k++) begin
        n_r[k] <= tcem_pkg::SUM_W'(pb_r[k]) + tcem_pkg::SUM_W'(pc_r[k]);
      end
      dd_r <= tcem_pkg::SUM_W'(dp1_r) - tcem_pkg::SUM_W'(dp2_r);
    end
  end

  always_comb begin
    logic signed [tcem_pkg::SUM_W-1:0] dabs;
    dabs = dd_r[tcem_pkg::SUM_W-1] ? -dd_r : dd_r;
    geo_nxt.degen = (dd_r == '0);
    for (int k = 0; k < tcem_pkg::NENT; k++) begin
      geo_nxt.nmag[k] = tcem_pkg::MAG_W'(n_r[k][tcem_pkg::SUM_W-1] ? -n_r[k] : n_r[k]);
      geo_nxt.neg[k]  = n_r[k][tcem_pkg::SUM_W-1] ^ dd_r[tcem_pkg::SUM_W-1];
    end
    geo_nxt.d = {dabs[tcem_pkg::DEN_W-2:0], 1'b0};
    // zero area: divide zero by one so every entry comes out zero
    if (geo_nxt.degen) begin
      geo_nxt.nmag = '0;
      geo_nxt.neg  = '0;
      geo_nxt.d    = tcem_pkg::DEN_W'(1);
    end
    if (dd_r[tcem_pkg::SUM_W-1:tcem_pkg::AREA_W-1] !=
        {(tcem_pkg::SUM_W-tcem_pkg::AREA_W+1){dd_r[tcem_pkg::SUM_W-1]}}) begin
      geo_nxt.area = dd_r[tcem_pkg::SUM_W-1] ? {1'b1, {(tcem_pkg::AREA_W-1){1'b0}}}
                                             : {1'b0, {(tcem_pkg::AREA_W-1){1'b1}}};
    end else begin
      geo_nxt.area = dd_r[tcem_pkg::AREA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r <= geo_nxt;
    end
  end

  assign geo = geo_r;
endmodule

// ===== rtl/core/tcem_step.sv =====
// One restoring division step, registered
`timescale 1ns / 1ps
module tcem_step (
  input  logic            clk,
  input  logic            en,
  input  tcem_pkg::step_t s_in,
  output tcem_pkg::step_t s_out
);
  tcem_pkg::step_t s_r, s_nxt;

  always_comb begin
    logic [tcem_pkg::DEN_W:0] r2;
    r2 = {s_in.rem, s_in.pl[tcem_pkg::Q_W-1]};
    s_nxt    = s_in;
    s_nxt.pl = {s_in.pl[tcem_pkg::Q_W-2:0], 1'b0};
    if (r2 >= {1'b0, s_in.d}) begin
      s_nxt.rem = tcem_pkg::DEN_W'(r2 - {1'b0, s_in.d});
      s_nxt.q   = {s_in.q[tcem_pkg::Q_W-2:0], 1'b1};
    end else begin
      s_nxt.rem = r2[tcem_pkg::DEN_W-1:0];
      s_nxt.q   = {s_in.q[tcem_pkg::Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s_out = s_r;
endmodule

// ===== rtl/core/tcem_lane.sv =====
// One matrix entry: split multiply by lambda, pipelined divide, saturation
`timescale 1ns / 1ps
module tcem_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tcem_pkg::LAM_W-1:0]  lam,
  input  logic [tcem_pkg::MAG_W-1:0]  nmag,
  input  logic                        neg,
  input  logic [tcem_pkg::DEN_W-1:0]  d,
  output logic [tcem_pkg::Q_W-1:0]    k
);
  logic [tcem_pkg::PP_W-1:0]  pp_lo_r, pp_hi_r;
  logic [tcem_pkg::DEN_W-1:0] d1_r, d2_r;
  logic                       neg1_r, neg2_r;
  logic [tcem_pkg::PRO_W-1:0] p_r;
  tcem_pkg::step_t            s0_r, s0_nxt;
  tcem_pkg::step_t            st [tcem_pkg::Q_W+1];
  logic [tcem_pkg::Q_W-1:0]   k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo_r <= lam * nmag[tcem_pkg::HALF_W-1:0];
      pp_hi_r <= lam * nmag[tcem_pkg::MAG_W-1:tcem_pkg::HALF_W];
      d1_r    <= d;
      neg1_r  <= neg;
      p_r     <= tcem_pkg::PRO_W'(pp_lo_r) + (tcem_pkg::PRO_W'(pp_hi_r) << tcem_pkg::HALF_W);
      d2_r    <= d1_r;
      neg2_r  <= neg1_r;
      s0_r    <= s0_nxt;
    end
  end

  // quotient of 2^32 or more is flagged up front; remaining steps form 32 bits
  always_comb begin
    s0_nxt.ovf = {1'b0, p_r[tcem_pkg::PRO_W-1:tcem_pkg::Q_W]} >= d2_r;
    s0_nxt.rem = {1'b0, p_r[tcem_pkg::PRO_W-1:tcem_pkg::Q_W]};
    s0_nxt.pl  = p_r[tcem_pkg::Q_W-1:0];
    s0_nxt.q   = '0;
    s0_nxt.d   = d2_r;
    s0_nxt.neg = neg2_r;
  end

  assign st[0] = s0_r;

  for (genvar i = 0; i < tcem_pkg::Q_W; i++) begin : g_step
    tcem_step u_step (
      .clk   (clk),
      .en    (en),
      .s_in  (st[i]),
      .s_out (st[i+1])
    );
  end

  always_comb begin
    tcem_pkg::step_t sf;
    sf = st[tcem_pkg::Q_W];
    if (sf.neg) begin
      k_nxt = (sf.ovf || sf.q[tcem_pkg::Q_W-1]) ? tcem_pkg::ENT_MIN : -sf.q;
    end else begin
      k_nxt = (sf.ovf || sf.q >= tcem_pkg::ENT_MAX) ? tcem_pkg::ENT_MAX : sf.q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_r <= k_nxt;
    end
  end

  assign k = k_r;
endmodule

// ===== rtl/core/triangle_conduction_element_matrix_core.sv =====
// Pipeline: 4 geometry + 36 per-entry stages from input accept to result valid.
// Throughput: one item per cycle when not stalled; each lane's 32-step divider sets depth.
// A stall on the result side freezes the whole pipe; nothing is lost or repeated.
// Reset: synchronous active-low; clears all valid bits, conductivity returns to 1.0.
`timescale 1ns / 1ps
`include "triangle_conduction_element_matrix_core_assert.svh"
module triangle_conduction_element_matrix_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y
  input  logic [tcem_pkg::IN_W-1:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // k_aa, k_ab, k_ac, k_bb, k_bc, k_cc, twice_area
  output logic [tcem_pkg::OUT_W-1:0]    out_tdata,
  // degenerate
  output logic                          out_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcem_pkg::LAM_W-1:0]    cfg_data
);
  logic                           en;
  logic [tcem_pkg::PIPE_LAT-1:0]  vld_r, vld_nxt;
  logic [tcem_pkg::LAM_W-1:0]     lam_r, lam_nxt;
  tcem_pkg::crd_t                 crd [tcem_pkg::NCRD];
  tcem_pkg::geo_t                 geo;
  logic [tcem_pkg::AREA_W-1:0]    area_r  [tcem_pkg::LANE_LAT];
  logic                           degen_r [tcem_pkg::LANE_LAT];
  logic [tcem_pkg::Q_W-1:0]       k_lane  [tcem_pkg::NENT];

  assign en        = !vld_r[tcem_pkg::PIPE_LAT-1] || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  assign vld_nxt = en ? {vld_r[tcem_pkg::PIPE_LAT-2:0], in_tvalid} : vld_r;
  assign lam_nxt = cfg_valid ? cfg_data : lam_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      lam_r <= tcem_pkg::LAM_RESET;
    end else begin
      vld_r <= vld_nxt;
      lam_r <= lam_nxt;
    end
  end

  for (genvar i = 0; i < tcem_pkg::NCRD; i++) begin : g_crd
    assign crd[i] = in_tdata[i*tcem_pkg::CRD_W +: tcem_pkg::CRD_W];
  end

  tcem_geom u_geom (
    .clk (clk),
    .en  (en),
    .crd (crd),
    .geo (geo)
  );

  for (genvar k = 0; k < tcem_pkg::NENT; k++) begin : g_lane
    tcem_lane u_lane (
      .clk  (clk),
      .en   (en),
      .lam  (lam_r),
      .nmag (geo.nmag[k]),
      .neg  (geo.neg[k]),
      .d    (geo.d),
      .k    (k_lane[k])
    );
    assign out_tdata[k*tcem_pkg::Q_W +: tcem_pkg::Q_W] = k_lane[k];
  end

  // area and flag ride alongside the divider lanes
  always_ff @(posedge clk) begin
    if (en) begin
      area_r[0]  <= geo.area;
      degen_r[0] <= geo.degen;
      for (int i = 1; i < tcem_pkg::LANE_LAT; i++) begin
        area_r[i]  <= area_r[i-1];
        degen_r[i] <= degen_r[i-1];
      end
    end
  end

  assign out_tdata[tcem_pkg::OUT_W-1:tcem_pkg::NENT*tcem_pkg::Q_W] =
    area_r[tcem_pkg::LANE_LAT-1];
  assign out_tuser  = degen_r[tcem_pkg::LANE_LAT-1];
  assign out_tvalid = vld_r[tcem_pkg::PIPE_LAT-1];

  `TCEM_ASSERT_ALWAYS(a_rst_clears, !rst_n |=> !out_tvalid, "valid after reset")
  `TCEM_ASSERT(a_degen_area, out_tvalid |-> (out_tuser == (out_tdata[239:192] == '0)), "flag vs area")
  `TCEM_ASSERT(a_degen_zero, (out_tvalid && out_tuser) |-> (out_tdata[191:0] == '0), "degenerate entries nonzero")
  `TCEM_ASSERT(a_diag_pos, (out_tvalid && !out_tuser && !out_tdata[239]) |-> !out_tdata[31], "k_aa sign")
  `TCEM_ASSERT(a_stall_hold, !en |=> (vld_r == $past(vld_r)), "pipe moved while stalled")
endmodule
